// ===== sv/nasch_pkg.sv =====
// Shared types and constants for the traffic vehicle update block.
// Beat layouts, status and operation codes, config register indexes.
// No dependencies.
`default_nettype none

package nasch_pkg;

    // Defaults for the top-level parameters
    localparam int LANE_CELLS_DEF    = 32;
    localparam int LANE_TOTAL_DEF    = 2;
    localparam int VEHICLE_SLOTS_DEF = 32;

    // Field widths fixed by the beat layouts
    localparam int SPEED_W     = 3;
    localparam int THRESH_W    = 7;
    localparam int SLOT_W      = 5;
    localparam int POS_W       = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int MAX_SPEED   = 7;

    // Operation codes
    localparam logic OP_PLACE  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_LEFT     = 2'd1;
    localparam logic [1:0] STATUS_ABSENT   = 2'd2;
    localparam logic [1:0] STATUS_OCCUPIED = 2'd3;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOWDOWN    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT = 1'd1;
    localparam logic [THRESH_W-1:0]    THRESH_RESET    = 7'd50;
    localparam logic [SPEED_W-1:0]     LIMIT_RESET     = 3'd5;

    typedef struct packed {
        logic                operation;
        logic [SLOT_W-1:0]   vehicle_index;
        logic                lane_index;
        logic [POS_W-1:0]    cell_position;
        logic [SPEED_W-1:0]  initial_speed;
        logic [THRESH_W-1:0] random_draw;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SPEED_W-1:0] result_speed;
        logic               result_lane;
        logic [POS_W-1:0]   result_position;
    } result_t;

    // Port command of a memory with one read port and one write port
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ===== sv/nasch_vehicle_mem.sv =====
// Vehicle table: speed, lane and cell per slot in a synchronous memory,
// present flags in flops cleared at reset. Depends on nasch_pkg.
`default_nettype none

module nasch_vehicle_mem
    import nasch_pkg::*;
#(
    parameter int VEHICLE_SLOTS = VEHICLE_SLOTS_DEF,
    parameter int LANE_W        = 1,
    parameter int CELL_W        = 5,
    parameter int ADDR_W        = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mem_cmd_t           cmd,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic               wr_present,
    input  wire logic [SPEED_W-1:0] wr_speed,
    input  wire logic [LANE_W-1:0]  wr_lane,
    input  wire logic [CELL_W-1:0]  wr_pos,
    output logic                    rd_present,
    output logic [SPEED_W-1:0]      rd_speed,
    output logic [LANE_W-1:0]       rd_lane,
    output logic [CELL_W-1:0]       rd_pos
);

    localparam int ENTRY_W = SPEED_W + LANE_W + CELL_W;

    logic [ENTRY_W-1:0]       entries [VEHICLE_SLOTS];
    logic [VEHICLE_SLOTS-1:0] present_reg;
    logic                     rd_present_reg;
    logic [ENTRY_W-1:0]       rd_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                present_reg[wr_addr] <= wr_present;
            end
            if (cmd.rd_en)
            begin
                rd_present_reg <= present_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entries[wr_addr] <= {wr_speed, wr_lane, wr_pos};
        end
        if (cmd.rd_en)
        begin
            rd_entry_reg <= entries[rd_addr];
        end
    end

    assign rd_present = rd_present_reg;
    assign {rd_speed, rd_lane, rd_pos} = rd_entry_reg;

endmodule

`default_nettype wire

// ===== sv/nasch_occ_mem.sv =====
// Cell occupancy map: one row of cell flags per lane in a synchronous
// memory; a row never written reads as empty. Depends on nasch_pkg.
`default_nettype none

module nasch_occ_mem
    import nasch_pkg::*;
#(
    parameter int LANE_CELLS = LANE_CELLS_DEF,
    parameter int LANE_TOTAL = LANE_TOTAL_DEF,
    parameter int LANE_W     = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mem_cmd_t              cmd,
    input  wire logic [LANE_W-1:0]     rd_addr,
    input  wire logic [LANE_W-1:0]     wr_addr,
    input  wire logic [LANE_CELLS-1:0] wr_row,
    output logic [LANE_CELLS-1:0]      rd_row
);

    logic [LANE_CELLS-1:0] rows [LANE_TOTAL];
    logic [LANE_TOTAL-1:0] row_valid_reg;
    logic                  rd_hit_reg;
    logic [LANE_CELLS-1:0] rd_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_hit_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            rows[wr_addr] <= wr_row;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg <= rows[rd_addr];
        end
    end

    // A lane not yet written holds stale data: show it empty
    assign rd_row = rd_hit_reg ? rd_row_reg : '0;

endmodule

`default_nettype wire

// ===== sv/nasch_traffic_vehicle_update.sv =====
// Top level of the traffic vehicle update block: sequencer, rule logic,
// config registers and result register. Depends on nasch_pkg,
// nasch_vehicle_mem and nasch_occ_mem.
//
// Nagel-Schreckenberg traffic update, one vehicle per beat. A place beat
// puts a vehicle on a free cell; an update beat accelerates, randomly slows,
// limits the move to the free gap ahead and moves the vehicle, which leaves
// once it passes the lane end. Each beat runs a read-modify-write over two
// memories in turn: the vehicle table, then the occupancy row of one lane;
// a beat whose answer is known from the vehicle entry alone ends after the
// vehicle read; a placement that moves a vehicle to another lane touches
// two occupancy rows. A beat holds the block from accept until its result is
// registered. The next beat is accepted in the cycle after the result is
// registered, even if that result is not yet taken; a beat whose result
// finds the previous one still waiting holds in its last state until that
// one is taken. No clearing pass is needed after reset. Config writes must
// go in only while the block is idle; the block itself does not enforce it.
`default_nettype none

module nasch_traffic_vehicle_update
    import nasch_pkg::*;
#(
    parameter int LANE_CELLS    = LANE_CELLS_DEF,
    parameter int LANE_TOTAL    = LANE_TOTAL_DEF,
    parameter int VEHICLE_SLOTS = VEHICLE_SLOTS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire item_t                  item,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_t                     result,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CELL_W  = $clog2(LANE_CELLS);
    localparam int LANE_W  = (LANE_TOTAL > 1) ? $clog2(LANE_TOTAL) : 1;
    localparam int ADDR_W  = (VEHICLE_SLOTS > 1) ? $clog2(VEHICLE_SLOTS) : 1;
    localparam int ROW_PAD = 2 ** CELL_W;

    localparam logic [8:0]      SLOT_LIMIT = 9'(VEHICLE_SLOTS);
    localparam logic [8:0]      LANE_LIMIT = 9'(LANE_TOTAL);
    localparam logic [8:0]      CELL_LIMIT = 9'(LANE_CELLS);
    localparam logic [CELL_W:0] CELL_END   = (CELL_W+1)'(LANE_CELLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_VREAD,
        S_PLACE_CHK,
        S_PLACE_OLD,
        S_UPD
    } state_t;

    state_t         state_reg, state_next;
    logic           result_valid_reg, result_valid_next;
    result_t        result_reg, result_next;
    item_t          item_reg;
    logic           load_item;
    logic [SPEED_W-1:0] v_reg, v_next;

    logic [THRESH_W-1:0] thresh_reg;
    logic [SPEED_W-1:0]  limit_reg;

    mem_cmd_t            veh_cmd;
    logic [ADDR_W-1:0]   veh_rd_addr;
    logic [ADDR_W-1:0]   veh_wr_addr;
    logic                veh_wr_present;
    logic [SPEED_W-1:0]  veh_wr_speed;
    logic [LANE_W-1:0]   veh_wr_lane;
    logic [CELL_W-1:0]   veh_wr_pos;
    logic                veh_present;
    logic [SPEED_W-1:0]  veh_speed;
    logic [LANE_W-1:0]   veh_lane;
    logic [CELL_W-1:0]   veh_pos;

    mem_cmd_t              occ_cmd;
    logic [LANE_W-1:0]     occ_rd_addr;
    logic [LANE_W-1:0]     occ_wr_addr;
    logic [LANE_CELLS-1:0] occ_wr_row;
    logic [LANE_CELLS-1:0] occ_rd_row;
    logic [ROW_PAD-1:0]    occ_row_pad;

    logic                in_slot_ok;
    logic                slot_ok;
    logic                road_ok;
    logic [ADDR_W-1:0]   slot_addr;
    logic [LANE_W-1:0]   new_lane;
    logic [CELL_W-1:0]   new_pos;
    logic [SPEED_W-1:0]  place_speed;
    logic [SPEED_W-1:0]  acc_v;
    logic                own_cell;
    logic [ROW_PAD-1:0]  place_row;
    logic [SPEED_W-1:0]  gap_v;
    logic [CELL_W:0]     up_np;
    logic                up_left;
    logic [ROW_PAD-1:0]  up_row;
    logic                can_finish;

    function automatic logic [ROW_PAD-1:0] cell_bit(input logic [CELL_W-1:0] p);
        cell_bit = ROW_PAD'(1) << p;
    endfunction

    function automatic result_t make_result(
        input logic [1:0]         st,
        input logic [SPEED_W-1:0] sp,
        input logic [LANE_W-1:0]  ln,
        input logic [CELL_W:0]    ps
    );
        result_t r;
        r.status          = st;
        r.result_speed    = sp;
        r.result_lane     = ln[0];
        r.result_position = POS_W'(ps);
        make_result = r;
    endfunction

    nasch_vehicle_mem #(
        .VEHICLE_SLOTS (VEHICLE_SLOTS),
        .LANE_W        (LANE_W),
        .CELL_W        (CELL_W),
        .ADDR_W        (ADDR_W)
    ) u_vehicle_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (veh_cmd),
        .rd_addr    (veh_rd_addr),
        .wr_addr    (veh_wr_addr),
        .wr_present (veh_wr_present),
        .wr_speed   (veh_wr_speed),
        .wr_lane    (veh_wr_lane),
        .wr_pos     (veh_wr_pos),
        .rd_present (veh_present),
        .rd_speed   (veh_speed),
        .rd_lane    (veh_lane),
        .rd_pos     (veh_pos)
    );

    nasch_occ_mem #(
        .LANE_CELLS (LANE_CELLS),
        .LANE_TOTAL (LANE_TOTAL),
        .LANE_W     (LANE_W)
    ) u_occ_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (occ_cmd),
        .rd_addr (occ_rd_addr),
        .wr_addr (occ_wr_addr),
        .wr_row  (occ_wr_row),
        .rd_row  (occ_rd_row)
    );

    // Decode of the held beat
    assign in_slot_ok  = {4'b0, item.vehicle_index} < SLOT_LIMIT;
    assign slot_ok     = {4'b0, item_reg.vehicle_index} < SLOT_LIMIT;
    assign road_ok     = ({8'b0, item_reg.lane_index} < LANE_LIMIT)
                      && ({4'b0, item_reg.cell_position} < CELL_LIMIT);
    assign slot_addr   = ADDR_W'(item_reg.vehicle_index);
    assign new_lane    = LANE_W'(item_reg.lane_index);
    assign new_pos     = CELL_W'(item_reg.cell_position);
    assign place_speed = (item_reg.initial_speed < limit_reg) ? item_reg.initial_speed
                                                              : limit_reg;
    assign occ_row_pad = ROW_PAD'(occ_rd_row);
    assign own_cell    = veh_present && (veh_lane == new_lane) && (veh_pos == new_pos);
    assign can_finish  = !result_valid_reg || result_ready;

    // Accelerate to the limit, then the random slowdown with a floor at zero
    always_comb
    begin
        logic [SPEED_W:0] acc;
        acc = {1'b0, veh_speed} + (SPEED_W+1)'(1);
        if (acc > {1'b0, limit_reg})
        begin
            acc_v = limit_reg;
        end
        else
        begin
            acc_v = acc[SPEED_W-1:0];
        end
        if ((item_reg.random_draw < thresh_reg) && (acc_v != '0))
        begin
            acc_v = acc_v - SPEED_W'(1);
        end
    end

    // Same-lane placement frees the old cell in the same row
    always_comb
    begin
        place_row = occ_row_pad;
        if (veh_present && (veh_lane == new_lane))
        begin
            place_row = place_row & ~cell_bit(veh_pos);
        end
        place_row = place_row | cell_bit(new_pos);
    end

    // Gap scan: stop at the first occupied cell ahead within the speed
    always_comb
    begin
        logic [CELL_W:0] scan_p;
        logic            found;
        found = 1'b0;
        gap_v = v_reg;
        for (int d = 1; d <= MAX_SPEED; d++)
        begin
            scan_p = {1'b0, veh_pos} + (CELL_W+1)'(d);
            if (!found && (SPEED_W'(d) <= v_reg) && (scan_p < CELL_END)
                && occ_row_pad[scan_p[CELL_W-1:0]])
            begin
                gap_v = SPEED_W'(d - 1);
                found = 1'b1;
            end
        end
        up_np   = {1'b0, veh_pos} + (CELL_W+1)'(gap_v);
        up_left = up_np >= CELL_END;
        up_row  = occ_row_pad & ~cell_bit(veh_pos);
        if (!up_left)
        begin
            up_row = up_row | cell_bit(up_np[CELL_W-1:0]);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        load_item         = 1'b0;
        v_next            = v_reg;
        veh_cmd           = '0;
        veh_rd_addr       = slot_addr;
        veh_wr_addr       = slot_addr;
        veh_wr_present    = 1'b1;
        veh_wr_speed      = place_speed;
        veh_wr_lane       = new_lane;
        veh_wr_pos        = new_pos;
        occ_cmd           = '0;
        occ_rd_addr       = new_lane;
        occ_wr_addr       = new_lane;
        occ_wr_row        = LANE_CELLS'(place_row);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    load_item     = 1'b1;
                    veh_cmd.rd_en = in_slot_ok;
                    veh_rd_addr   = ADDR_W'(item.vehicle_index);
                    state_next    = S_VREAD;
                end
            end

            S_VREAD:
            begin
                if (!slot_ok)
                begin
                    if (can_finish)
                    begin
                        result_valid_next = 1'b1;
                        result_next = make_result(STATUS_ABSENT, '0, '0, '0);
                        state_next  = S_IDLE;
                    end
                end
                else if (item_reg.operation == OP_PLACE)
                begin
                    if (!road_ok)
                    begin
                        if (can_finish)
                        begin
                            result_valid_next = 1'b1;
                            result_next = make_result(STATUS_OCCUPIED, '0, '0, '0);
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        occ_cmd.rd_en = 1'b1;
                        state_next    = S_PLACE_CHK;
                    end
                end
                else if (!veh_present)
                begin
                    if (can_finish)
                    begin
                        result_valid_next = 1'b1;
                        result_next = make_result(STATUS_ABSENT, '0, '0, '0);
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    v_next        = acc_v;
                    occ_cmd.rd_en = 1'b1;
                    occ_rd_addr   = veh_lane;
                    state_next    = S_UPD;
                end
            end

            S_PLACE_CHK:
            begin
                if (occ_row_pad[new_pos] && !own_cell)
                begin
                    if (can_finish)
                    begin
                        result_valid_next = 1'b1;
                        result_next = make_result(STATUS_OCCUPIED, '0, '0, '0);
                        state_next  = S_IDLE;
                    end
                end
                else if (veh_present && (veh_lane != new_lane))
                begin
                    // Claim the new row now, free the old row in S_PLACE_OLD
                    occ_cmd.wr_en = 1'b1;
                    occ_cmd.rd_en = 1'b1;
                    occ_rd_addr   = veh_lane;
                    veh_cmd.wr_en = 1'b1;
                    state_next    = S_PLACE_OLD;
                end
                else if (can_finish)
                begin
                    occ_cmd.wr_en     = 1'b1;
                    veh_cmd.wr_en     = 1'b1;
                    result_valid_next = 1'b1;
                    result_next = make_result(STATUS_DONE, place_speed, new_lane,
                                              {1'b0, new_pos});
                    state_next  = S_IDLE;
                end
            end

            S_PLACE_OLD:
            begin
                if (can_finish)
                begin
                    occ_cmd.wr_en     = 1'b1;
                    occ_wr_addr       = veh_lane;
                    occ_wr_row        = LANE_CELLS'(occ_row_pad & ~cell_bit(veh_pos));
                    result_valid_next = 1'b1;
                    result_next = make_result(STATUS_DONE, place_speed, new_lane,
                                              {1'b0, new_pos});
                    state_next  = S_IDLE;
                end
            end

            S_UPD:
            begin
                if (can_finish)
                begin
                    occ_cmd.wr_en     = 1'b1;
                    occ_wr_addr       = veh_lane;
                    occ_wr_row        = LANE_CELLS'(up_row);
                    veh_cmd.wr_en     = 1'b1;
                    veh_wr_present    = !up_left;
                    veh_wr_speed      = gap_v;
                    veh_wr_lane       = veh_lane;
                    veh_wr_pos        = up_np[CELL_W-1:0];
                    result_valid_next = 1'b1;
                    if (up_left)
                    begin
                        result_next = make_result(STATUS_LEFT, '0, '0, '0);
                    end
                    else
                    begin
                        result_next = make_result(STATUS_DONE, gap_v, veh_lane, up_np);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            v_reg            <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            v_reg            <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SLOWDOWN:    thresh_reg <= cfg_data;
                CFG_SPEED_LIMIT: limit_reg  <= cfg_data[SPEED_W-1:0];
                default:         thresh_reg <= thresh_reg;
            endcase
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_occ_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_cmd.rd_en && occ_cmd.wr_en) |-> (occ_rd_addr != occ_wr_addr))
        else $error("occupancy row read and written in the same cycle");

    a_veh_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(veh_cmd.rd_en && veh_cmd.wr_en))
        else $error("vehicle table read and written in the same cycle");

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_VREAD))
        else $error("accepted beat did not start the vehicle read");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result raised without a beat in work");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for nasch_traffic_vehicle_update: a short directed script of place and
// update beats, then random phases across several register settings.
// Depends on nasch_pkg and the RTL; checks scripted answers and its own traffic-rule model.
`default_nettype none

module testbench
    import nasch_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS        = LANE_CELLS_DEF;
    localparam int LANES        = LANE_TOTAL_DEF;
    localparam int SLOTS        = VEHICLE_SLOTS_DEF;
    localparam int PHASE_BEATS  = 190;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PERCENT = 17;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic               present;
        logic [SPEED_W-1:0] speed;
        logic               lane;
        logic [POS_W-1:0]   pos;
    } vehicle_t;

    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } script_row_t;

    typedef struct {
        logic [THRESH_W-1:0] threshold;
        logic [SPEED_W-1:0]  limit;
    } setting_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // typed expectation that travels with the beat on the item channel
    bit      beat_typed = 1'b0;
    result_t beat_want = '0;

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit hold_served = 1'b0;
    int failures = 0;
    int cycle_count = 0;

    // traffic model state
    vehicle_t            fleet [SLOTS];
    logic                road [LANES][CELLS];
    logic [THRESH_W-1:0] slow_threshold = THRESH_RESET;
    logic [SPEED_W-1:0]  speed_cap = LIMIT_RESET;
    result_t             outcomes_due [$];

    script_row_t script [17] = '{
        '{'{OP_UPDATE, 5'd0, 1'b0, 5'd0, 3'd0, 7'd0}, 1'b1, '{STATUS_ABSENT, 3'd0, 1'b0, 5'd0}},
        '{'{OP_PLACE, 5'd0, 1'b0, 5'd0, 3'd7, 7'd0}, 1'b1, '{STATUS_DONE, 3'd5, 1'b0, 5'd0}},
        '{'{OP_PLACE, 5'd1, 1'b0, 5'd0, 3'd0, 7'd0}, 1'b1, '{STATUS_OCCUPIED, 3'd0, 1'b0, 5'd0}},
        '{'{OP_PLACE, 5'd31, 1'b1, 5'd31, 3'd0, 7'd127}, 1'b1,
          '{STATUS_DONE, 3'd0, 1'b1, 5'd31}},
        '{'{OP_UPDATE, 5'd31, 1'b0, 5'd0, 3'd0, 7'd127}, 1'b1, '{STATUS_LEFT, 3'd0, 1'b0, 5'd0}},
        '{'{OP_UPDATE, 5'd31, 1'b1, 5'd31, 3'd7, 7'd0}, 1'b1, '{STATUS_ABSENT, 3'd0, 1'b0, 5'd0}},
        '{'{OP_PLACE, 5'd1, 1'b0, 5'd2, 3'd3, 7'd0}, 1'b1, '{STATUS_DONE, 3'd3, 1'b0, 5'd2}},
        '{'{OP_UPDATE, 5'd0, 1'b0, 5'd0, 3'd0, 7'd99}, 1'b0, '0},
        '{'{OP_UPDATE, 5'd0, 1'b0, 5'd0, 3'd0, 7'd0}, 1'b0, '0},
        '{'{OP_UPDATE, 5'd0, 1'b0, 5'd0, 3'd0, 7'd127}, 1'b0, '0},
        '{'{OP_PLACE, 5'd1, 1'b0, 5'd2, 3'd7, 7'd0}, 1'b1, '{STATUS_DONE, 3'd5, 1'b0, 5'd2}},
        '{'{OP_PLACE, 5'd1, 1'b1, 5'd10, 3'd2, 7'd0}, 1'b1, '{STATUS_DONE, 3'd2, 1'b1, 5'd10}},
        '{'{OP_PLACE, 5'd0, 1'b1, 5'd10, 3'd4, 7'd0}, 1'b1,
          '{STATUS_OCCUPIED, 3'd0, 1'b0, 5'd0}},
        '{'{OP_UPDATE, 5'd0, 1'b0, 5'd0, 3'd0, 7'd127}, 1'b0, '0},
        '{'{OP_PLACE, 5'd2, 1'b0, 5'd31, 3'd7, 7'd0}, 1'b1, '{STATUS_DONE, 3'd5, 1'b0, 5'd31}},
        '{'{OP_UPDATE, 5'd2, 1'b0, 5'd0, 3'd0, 7'd127}, 1'b1, '{STATUS_LEFT, 3'd0, 1'b0, 5'd0}},
        '{'{OP_UPDATE, 5'd1, 1'b0, 5'd0, 3'd0, 7'd127}, 1'b0, '0}
    };

    setting_t settings [8] = '{
        '{7'd50, 3'd5}, '{7'd0, 3'd7}, '{7'd127, 3'd0}, '{7'd100, 3'd1},
        '{7'd127, 3'd7}, '{7'd0, 3'd1}, '{7'd99, 3'd3}, '{7'd63, 3'd6}
    };

    nasch_traffic_vehicle_update i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    initial begin
        foreach (fleet[i])
            fleet[i] = '0;
        foreach (road[l, c])
            road[l][c] = 1'b0;
    end

    // Place or move one vehicle and return the answer the block must give.
    function automatic result_t apply_traffic_rules(input item_t b);
        result_t    r;
        vehicle_t   car;
        logic [3:0] v;
        logic [5:0] ahead;
        logic [5:0] landing;
        r = '0;
        car = fleet[b.vehicle_index];
        if (b.operation == OP_PLACE) begin
            // a vehicle re-placed on its own cell does not block itself
            if (road[b.lane_index][b.cell_position] &&
                !(car.present && car.lane == b.lane_index && car.pos == b.cell_position)) begin
                r.status = STATUS_OCCUPIED;
                return r;
            end
            if (car.present)
                road[car.lane][car.pos] = 1'b0;
            car.present = 1'b1;
            car.speed = (b.initial_speed < speed_cap) ? b.initial_speed : speed_cap;
            car.lane = b.lane_index;
            car.pos = b.cell_position;
            road[car.lane][car.pos] = 1'b1;
            fleet[b.vehicle_index] = car;
            r = '{STATUS_DONE, car.speed, car.lane, car.pos};
            return r;
        end
        if (!car.present) begin
            r.status = STATUS_ABSENT;
            return r;
        end
        v = {1'b0, car.speed} + 4'd1;
        if (v > {1'b0, speed_cap})
            v = {1'b0, speed_cap};
        if (b.random_draw < slow_threshold && v > 4'd0)
            v = v - 4'd1;
        // stop short of the first vehicle ahead; the lane end sets no limit
        for (int d = 1; d <= v; d++) begin
            ahead = {1'b0, car.pos} + 6'(d);
            if (ahead >= 6'(CELLS))
                break;
            if (road[car.lane][ahead[POS_W-1:0]]) begin
                v = 4'(d - 1);
                break;
            end
        end
        landing = {1'b0, car.pos} + {2'b00, v};
        road[car.lane][car.pos] = 1'b0;
        if (landing >= 6'(CELLS)) begin
            fleet[b.vehicle_index] = '0;
            r.status = STATUS_LEFT;
            return r;
        end
        car.speed = v[SPEED_W-1:0];
        car.pos = landing[POS_W-1:0];
        road[car.lane][car.pos] = 1'b1;
        fleet[b.vehicle_index] = car;
        r = '{STATUS_DONE, car.speed, car.lane, car.pos};
        return r;
    endfunction

    function automatic item_t random_beat();
        item_t b;
        int    start;
        b.operation = ($urandom_range(0, 99) < 35) ? OP_PLACE : OP_UPDATE;
        b.vehicle_index = SLOT_W'($urandom_range(0, SLOTS - 1));
        b.lane_index = 1'($urandom_range(0, 1));
        b.cell_position = POS_W'($urandom_range(0, 31));
        b.initial_speed = SPEED_W'($urandom_range(0, 7));
        b.random_draw = THRESH_W'($urandom_range(0, 127));
        // steer most updates onto a vehicle that is on the road
        if (b.operation == OP_UPDATE && $urandom_range(0, 99) < 70) begin
            start = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++) begin
                if (fleet[(start + k) % SLOTS].present) begin
                    b.vehicle_index = SLOT_W'((start + k) % SLOTS);
                    break;
                end
            end
        end
        return b;
    endfunction

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // Offer one beat, idling first at random; return at the edge that takes it.
    task automatic send_beat(input item_t b, input bit typed, input result_t want);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= b;
        beat_typed <= typed;
        beat_want <= want;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic drain();
        @(posedge clk);
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input setting_t s);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SLOWDOWN;
        cfg_data <= CFG_DATA_W'(s.threshold);
        @(posedge clk);
        cfg_index <= CFG_SPEED_LIMIT;
        cfg_data <= CFG_DATA_W'(s.limit);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Score results, predict accepted beats, track register writes.
    always @(posedge clk) begin : scoreboard
        result_t want;
        result_t guess;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (outcomes_due.size() == 0) begin
                    log_failure($sformatf("unexpected result beat %h", result));
                end else begin
                    want = outcomes_due.pop_front();
                    if (want.status != result.status ||
                        want.result_speed != result.result_speed ||
                        want.result_lane != result.result_lane ||
                        want.result_position != result.result_position)
                        log_failure($sformatf(
                            "mismatch: expected st/speed/lane/cell %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                            want.status, want.result_speed, want.result_lane,
                            want.result_position, result.status, result.result_speed,
                            result.result_lane, result.result_position));
                end
            end
            if (item_valid && item_ready) begin
                guess = apply_traffic_rules(item);
                outcomes_due.push_back(beat_typed ? beat_want : guess);
            end
            if (cfg_write) begin
                case (cfg_index)
                    CFG_SLOWDOWN:    slow_threshold = cfg_data[THRESH_W-1:0];
                    CFG_SPEED_LIMIT: speed_cap = cfg_data[SPEED_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[nasch_traffic_vehicle_update] ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_beat(script[i].beat, script[i].typed, script[i].want);
        item_valid <= 1'b0;
        beat_typed <= 1'b0;

        foreach (settings[p]) begin
            drain();
            program_registers(settings[p]);
            calm = (p == 2);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 1 && n == 40)
                    hold_request <= 1'b1;
                send_beat(random_beat(), 1'b0, '0);
            end
            item_valid <= 1'b0;
        end
        calm = 1'b0;
        drain();

        failures += outcomes_due.size();
        if (outcomes_due.size() != 0)
            $display("%0d expected results never arrived", outcomes_due.size());
        if (failures == 0)
            $display("[nasch_traffic_vehicle_update] OK");
        else
            $display("[nasch_traffic_vehicle_update] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/nasch_pkg.sv
sv/nasch_vehicle_mem.sv
sv/nasch_occ_mem.sv
sv/nasch_traffic_vehicle_update.sv
test/testbench.sv
